>>> rtl/pdx_pkg.sv
`timescale 1ns / 1ps

package pdx_pkg;

	localparam int unsigned HEAD_DEPTH = 7;

	typedef logic [2:0] status_t;
	typedef logic [2:0] position_t;

	localparam status_t STATUS_OK        = 3'd0;
	localparam status_t STATUS_BAD_CHECK = 3'd1;
	localparam status_t STATUS_BAD_ADDR  = 3'd2;
	localparam status_t STATUS_BAD_START = 3'd3;
	localparam status_t STATUS_BAD_LEN   = 3'd4;

	typedef logic [0:0] reg_index_t;

	localparam reg_index_t REG_OWN_ADDRESS = 1'b0;
	localparam reg_index_t REG_START_BYTE  = 1'b1;

	localparam logic [7:0] OWN_ADDRESS_RESET = 8'h05;
	localparam logic [7:0] START_BYTE_RESET  = 8'h02;

	localparam logic [7:0] LEN_SHORT  = 8'h05;
	localparam logic [7:0] LEN_MEDIUM = 8'h06;
	localparam logic [7:0] LEN_LONG   = 8'h07;

	// head byte positions
	localparam position_t POS_START = 3'd0;
	localparam position_t POS_LEN   = 3'd1;
	localparam position_t POS_DEST  = 3'd2;
	localparam position_t POS_SRC   = 3'd3;
	localparam position_t POS_CMD   = 3'd4;
	localparam position_t POS_DATA1 = 3'd5;
	localparam position_t POS_DATA2 = 3'd6;
	localparam position_t POS_FULL  = 3'd7;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_message;
	} rx_item_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] length_field;
		logic [7:0] source_address;
		logic [7:0] command;
		logic [7:0] data_first;
		logic [7:0] data_second;
	} verdict_t;

endpackage

>>> rtl/pdx_rx_if.sv
`timescale 1ns / 1ps

interface pdx_rx_if;
	logic              valid;
	logic              ready;
	pdx_pkg::rx_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/pdx_verdict_if.sv
`timescale 1ns / 1ps

interface pdx_verdict_if;
	logic              valid;
	logic              ready;
	pdx_pkg::verdict_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/packet_deframer_xor_check_core.sv
`timescale 1ns / 1ps

// channel    | dir | payload                                        | transfer
// rx         | in  | rx_byte, end_of_message                         | valid & ready
// verdict    | out | status, length_field, source_address, command,  | valid & ready
//            |     | data_first, data_second                         |
// cfg        | in  | cfg_we, cfg_index, cfg_data                     | cfg_we
//
// one byte per cycle while rx.ready is high; a verdict appears in the cycle after the final byte's transfer
// the verdict sits in a single output register; rx is taken whenever that register
// is empty or being emptied in the same cycle, so a full rate stream stalls only on a held verdict
// arst_n clears configuration to its defaults and all message state to zero
// a stalled verdict holds rx only while the output register stays full

module packet_deframer_xor_check_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  pdx_pkg::reg_index_t     cfg_index,
	input  logic [7:0]              cfg_data,
	pdx_rx_if.sink                  rx,
	pdx_verdict_if.source           verdict
);

	logic [7:0]          own_address_q;
	logic [7:0]          start_byte_q;
	logic [7:0]          running_xor_q;
	pdx_pkg::position_t  byte_position_q;
	logic [7:0]          head_q [pdx_pkg::HEAD_DEPTH];
	logic                out_valid_q;
	pdx_pkg::verdict_t   out_q;

	logic                rx_xfer;
	logic                last_byte;
	logic [7:0]          cur_byte;
	logic                store_en;
	logic [7:0]          head_now [pdx_pkg::HEAD_DEPTH];
	pdx_pkg::verdict_t   verdict_d;

	assign cur_byte  = rx.payload.rx_byte;
	assign last_byte = rx.payload.end_of_message;
	assign rx.ready  = !out_valid_q || verdict.ready;
	assign rx_xfer   = rx.valid && rx.ready;
	assign store_en  = byte_position_q != pdx_pkg::POS_FULL;

	// head bytes as seen after storing the current byte
	always_comb begin
		for (int i = 0; i < pdx_pkg::HEAD_DEPTH; i++) begin
			if (store_en && byte_position_q == pdx_pkg::position_t'(i)) begin
				head_now[i] = cur_byte;
			end else begin
				head_now[i] = head_q[i];
			end
		end
	end

	always_comb begin
		verdict_d = '0;
		if (head_now[pdx_pkg::POS_START] != start_byte_q) begin
			verdict_d.status = pdx_pkg::STATUS_BAD_START;
		end else if (running_xor_q != cur_byte) begin
			verdict_d.status = pdx_pkg::STATUS_BAD_CHECK;
		end else if (head_now[pdx_pkg::POS_DEST] != own_address_q) begin
			verdict_d.status = pdx_pkg::STATUS_BAD_ADDR;
		end else begin
			verdict_d.length_field   = head_now[pdx_pkg::POS_LEN];
			verdict_d.source_address = head_now[pdx_pkg::POS_SRC];
			verdict_d.command        = head_now[pdx_pkg::POS_CMD];
			case (head_now[pdx_pkg::POS_LEN])
				pdx_pkg::LEN_SHORT: begin
					verdict_d.status = pdx_pkg::STATUS_OK;
				end
				pdx_pkg::LEN_MEDIUM: begin
					verdict_d.status     = pdx_pkg::STATUS_OK;
					verdict_d.data_first = head_now[pdx_pkg::POS_DATA1];
				end
				pdx_pkg::LEN_LONG: begin
					verdict_d.status      = pdx_pkg::STATUS_OK;
					verdict_d.data_first  = head_now[pdx_pkg::POS_DATA1];
					verdict_d.data_second = head_now[pdx_pkg::POS_DATA2];
				end
				default: begin
					verdict_d.status = pdx_pkg::STATUS_BAD_LEN;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= pdx_pkg::OWN_ADDRESS_RESET;
			start_byte_q  <= pdx_pkg::START_BYTE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pdx_pkg::REG_OWN_ADDRESS: own_address_q <= cfg_data;
				pdx_pkg::REG_START_BYTE:  start_byte_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_xor_q   <= '0;
			byte_position_q <= '0;
			for (int i = 0; i < pdx_pkg::HEAD_DEPTH; i++) begin
				head_q[i] <= '0;
			end
		end else if (rx_xfer) begin
			if (last_byte) begin
				// message done: start clean for the next one
				running_xor_q   <= '0;
				byte_position_q <= '0;
				for (int i = 0; i < pdx_pkg::HEAD_DEPTH; i++) begin
					head_q[i] <= '0;
				end
			end else begin
				running_xor_q <= running_xor_q ^ cur_byte;
				if (store_en) begin
					byte_position_q <= byte_position_q + 3'd1;
				end
				for (int i = 0; i < pdx_pkg::HEAD_DEPTH; i++) begin
					head_q[i] <= head_now[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rx_xfer && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_xfer && last_byte) begin
			out_q <= verdict_d;
		end
	end

	assign verdict.valid   = out_valid_q;
	assign verdict.payload = out_q;

`ifndef SYNTHESIS
	a_verdict_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		rx_xfer && last_byte |=> out_valid_q)
		else $error("no verdict after final byte");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		rx_xfer && last_byte |=> running_xor_q == 8'h00 && byte_position_q == 3'd0)
		else $error("message state not cleared");

	a_ok_has_valid_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == pdx_pkg::STATUS_OK |->
		out_q.length_field == pdx_pkg::LEN_SHORT ||
		out_q.length_field == pdx_pkg::LEN_MEDIUM ||
		out_q.length_field == pdx_pkg::LEN_LONG)
		else $error("ok verdict with bad length");

	a_failed_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != pdx_pkg::STATUS_OK &&
		out_q.status != pdx_pkg::STATUS_BAD_LEN |->
		out_q.length_field == 8'h00 && out_q.source_address == 8'h00 &&
		out_q.command == 8'h00)
		else $error("failed verdict carries fields");

	a_data_second_needs_long: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.data_second != 8'h00 |->
		out_q.length_field == pdx_pkg::LEN_LONG)
		else $error("second data byte without length seven");
`endif

endmodule

>>> bench/tb_packet_deframer_xor_check_core.sv
`timescale 1ns / 1ps

module tb_packet_deframer_xor_check_core;

	localparam int PHASE_BYTES  = 210;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	pdx_pkg::reg_index_t cfg_index;
	logic [7:0]          cfg_data;

	pdx_rx_if      rx_bus ();
	pdx_verdict_if verdict_bus ();

	packet_deframer_xor_check_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx_bus),
		.verdict   (verdict_bus)
	);

	// own copy of the register values and message state
	logic [7:0]         own_addr;
	logic [7:0]         start_val;
	logic [7:0]         rx_xor;
	pdx_pkg::position_t rx_pos;
	logic [7:0]         rx_head [pdx_pkg::HEAD_DEPTH];

	pdx_pkg::rx_item_t bytes_to_send [$];
	pdx_pkg::verdict_t verdicts_due [$];
	logic [7:0]        msg_body [$];

	int send_idle_pct;
	int ready_stall_pct;
	int hold_left;
	int cycle_count;
	int error_count;
	int bytes_accepted;
	int verdicts_checked;
	int status_seen [5];

	always #6 clk = ~clk;

	// consumes one accepted byte, queues a verdict on the flagged one
	task automatic absorb_byte(input logic [7:0] b, input logic eom);
		pdx_pkg::verdict_t v;
		begin
			v = '0;
			if (rx_pos < pdx_pkg::POS_FULL) begin
				rx_head[rx_pos] = b;
				rx_pos = rx_pos + 3'd1;
			end
			if (!eom) begin
				rx_xor = rx_xor ^ b;
				return;
			end
			if (rx_head[pdx_pkg::POS_START] != start_val) begin
				v.status = pdx_pkg::STATUS_BAD_START;
			end else if (rx_xor != b) begin
				v.status = pdx_pkg::STATUS_BAD_CHECK;
			end else if (rx_head[pdx_pkg::POS_DEST] != own_addr) begin
				v.status = pdx_pkg::STATUS_BAD_ADDR;
			end else begin
				v.length_field   = rx_head[pdx_pkg::POS_LEN];
				v.source_address = rx_head[pdx_pkg::POS_SRC];
				v.command        = rx_head[pdx_pkg::POS_CMD];
				case (rx_head[pdx_pkg::POS_LEN])
					pdx_pkg::LEN_SHORT: begin
						v.status = pdx_pkg::STATUS_OK;
					end
					pdx_pkg::LEN_MEDIUM: begin
						v.status     = pdx_pkg::STATUS_OK;
						v.data_first = rx_head[pdx_pkg::POS_DATA1];
					end
					pdx_pkg::LEN_LONG: begin
						v.status      = pdx_pkg::STATUS_OK;
						v.data_first  = rx_head[pdx_pkg::POS_DATA1];
						v.data_second = rx_head[pdx_pkg::POS_DATA2];
					end
					default: begin
						v.status = pdx_pkg::STATUS_BAD_LEN;
					end
				endcase
			end
			verdicts_due.push_back(v);
			rx_xor = '0;
			rx_pos = '0;
			foreach (rx_head[i]) rx_head[i] = '0;
		end
	endtask

	task automatic check_field(input string field, input logic [7:0] want,
		input logic [7:0] got);
		begin
			if (want !== got) begin
				$display("%0t %s mismatch: expected %0h actual %0h", $time, field, want, got);
				error_count++;
			end
		end
	endtask

	// sends msg_body followed by its xor check byte, optionally spoiled
	task automatic close_message(input bit spoil_check);
		pdx_pkg::rx_item_t item;
		logic [7:0]        ck;
		begin
			ck = '0;
			foreach (msg_body[i]) begin
				ck = ck ^ msg_body[i];
				item.rx_byte = msg_body[i];
				item.end_of_message = 1'b0;
				bytes_to_send.push_back(item);
			end
			if (spoil_check)
				ck = ck ^ 8'($urandom_range(255, 1));
			item.rx_byte = ck;
			item.end_of_message = 1'b1;
			bytes_to_send.push_back(item);
		end
	endtask

	task automatic queue_random_message();
		pdx_pkg::rx_item_t item;
		int                kind;
		int                len;
		int                n;
		begin
			kind = $urandom_range(99);
			if (kind >= 95) begin
				// noise, flags at random, may leave a partial message behind
				n = $urandom_range(10, 1);
				repeat (n) begin
					item.rx_byte = 8'($urandom);
					item.end_of_message = ($urandom_range(99) < 30);
					bytes_to_send.push_back(item);
				end
				return;
			end
			len = $urandom_range(7, 5);
			msg_body.delete();
			msg_body.push_back(start_val);
			msg_body.push_back(8'(len));
			msg_body.push_back(own_addr);
			repeat (len - 2) msg_body.push_back(8'($urandom));
			if (kind < 55) begin
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(5, 1)) msg_body.push_back(8'($urandom));
			end else if (kind < 62) begin
				msg_body[pdx_pkg::POS_START] = start_val ^ 8'($urandom_range(255, 1));
			end else if (kind < 76 && kind >= 69) begin
				msg_body[pdx_pkg::POS_DEST] = own_addr ^ 8'($urandom_range(255, 1));
			end else if (kind < 83 && kind >= 76) begin
				msg_body[pdx_pkg::POS_LEN] = 8'($urandom);
				if (msg_body[pdx_pkg::POS_LEN] >= pdx_pkg::LEN_SHORT &&
					msg_body[pdx_pkg::POS_LEN] <= pdx_pkg::LEN_LONG)
					msg_body[pdx_pkg::POS_LEN] = msg_body[pdx_pkg::POS_LEN] ^ 8'h10;
			end else if (kind < 90 && kind >= 83) begin
				n = $urandom_range(len - 1, 0);
				while (msg_body.size() > n) void'(msg_body.pop_back());
			end else if (kind >= 90) begin
				repeat ($urandom_range(10, 3)) msg_body.push_back(8'($urandom));
			end
			close_message(kind >= 62 && kind < 69);
		end
	endtask

	task automatic write_register(input pdx_pkg::reg_index_t idx, input logic [7:0] value);
		begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= value;
			@(posedge clk);
			cfg_we <= 1'b0;
			if (idx == pdx_pkg::REG_OWN_ADDRESS)
				own_addr = value;
			else
				start_val = value;
		end
	endtask

	task automatic wait_drained();
		begin
			while (bytes_to_send.size() != 0 || rx_bus.valid || verdicts_due.size() != 0)
				@(negedge clk);
			// a trailing unflagged byte may still be in flight
			repeat (DRAIN_CYCLES) @(negedge clk);
		end
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input bit with_hold);
		begin
			@(negedge clk);
			send_idle_pct   = idle_pct;
			ready_stall_pct = stall_pct;
			while (bytes_to_send.size() < PHASE_BYTES) queue_random_message();
			if (with_hold)
				hold_left = HOLD_CYCLES;
			wait_drained();
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_bus.valid <= 1'b0;
		end else if (!rx_bus.valid || rx_bus.ready) begin
			if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				rx_bus.payload <= bytes_to_send.pop_front();
				rx_bus.valid   <= 1'b1;
			end else begin
				rx_bus.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		pdx_pkg::verdict_t want;
		if (arst_n) begin
			if (rx_bus.valid && rx_bus.ready) begin
				bytes_accepted++;
				absorb_byte(rx_bus.payload.rx_byte, rx_bus.payload.end_of_message);
			end
			if (verdict_bus.valid && verdict_bus.ready) begin
				if (verdicts_due.size() == 0) begin
					$display("%0t unexpected verdict: expected none actual %0h",
						$time, verdict_bus.payload);
					error_count++;
				end else begin
					want = verdicts_due.pop_front();
					verdicts_checked++;
					status_seen[want.status]++;
					check_field("status", 8'(want.status), 8'(verdict_bus.payload.status));
					check_field("length_field", want.length_field,
						verdict_bus.payload.length_field);
					check_field("source_address", want.source_address,
						verdict_bus.payload.source_address);
					check_field("command", want.command, verdict_bus.payload.command);
					check_field("data_first", want.data_first, verdict_bus.payload.data_first);
					check_field("data_second", want.data_second,
						verdict_bus.payload.data_second);
				end
			end
		end
		verdict_bus.ready <= arst_n && hold_left == 0 && $urandom_range(99) >= ready_stall_pct;
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d verdicts outstanding",
				cycle_count, verdicts_due.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = pdx_pkg::REG_OWN_ADDRESS;
		cfg_data          = '0;
		rx_bus.valid      = 1'b0;
		rx_bus.payload    = '0;
		verdict_bus.ready = 1'b0;
		own_addr          = pdx_pkg::OWN_ADDRESS_RESET;
		start_val         = pdx_pkg::START_BYTE_RESET;
		rx_xor            = '0;
		rx_pos            = '0;
		foreach (rx_head[i]) rx_head[i] = '0;
		foreach (status_seen[i]) status_seen[i] = 0;
		send_idle_pct     = 0;
		ready_stall_pct   = 0;
		hold_left         = 0;
		cycle_count       = 0;
		error_count       = 0;
		bytes_accepted    = 0;
		verdicts_checked  = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under reset register values
		@(negedge clk);
		// too short: check byte lands in the source slot
		msg_body = {pdx_pkg::START_BYTE_RESET, pdx_pkg::LEN_SHORT,
			pdx_pkg::OWN_ADDRESS_RESET};
		close_message(1'b0);
		msg_body = {pdx_pkg::START_BYTE_RESET, pdx_pkg::LEN_MEDIUM,
			pdx_pkg::OWN_ADDRESS_RESET, 8'hff, 8'h00, 8'hff};
		close_message(1'b0);
		// one-byte messages, xor over nothing is zero
		msg_body.delete();
		close_message(1'b0);
		bytes_to_send.push_back('{rx_byte: pdx_pkg::START_BYTE_RESET, end_of_message: 1'b1});
		msg_body = {pdx_pkg::START_BYTE_RESET, pdx_pkg::LEN_SHORT,
			pdx_pkg::OWN_ADDRESS_RESET};
		close_message(1'b1);
		msg_body = {pdx_pkg::START_BYTE_RESET, pdx_pkg::LEN_SHORT, 8'h06};
		close_message(1'b0);
		msg_body = {pdx_pkg::START_BYTE_RESET, 8'hff, pdx_pkg::OWN_ADDRESS_RESET};
		close_message(1'b0);
		wait_drained();

		write_register(pdx_pkg::REG_OWN_ADDRESS, 8'h00);
		write_register(pdx_pkg::REG_START_BYTE, 8'hff);
		run_phase(0, 0, 1'b0);

		write_register(pdx_pkg::REG_OWN_ADDRESS, 8'hff);
		write_register(pdx_pkg::REG_START_BYTE, 8'h00);
		run_phase(85, 0, 1'b0);

		write_register(pdx_pkg::REG_OWN_ADDRESS, 8'($urandom));
		write_register(pdx_pkg::REG_START_BYTE, 8'($urandom));
		run_phase(0, 85, 1'b0);

		write_register(pdx_pkg::REG_OWN_ADDRESS, pdx_pkg::OWN_ADDRESS_RESET);
		write_register(pdx_pkg::REG_START_BYTE, pdx_pkg::START_BYTE_RESET);
		run_phase(29, 29, 1'b0);

		write_register(pdx_pkg::REG_OWN_ADDRESS, 8'h00);
		write_register(pdx_pkg::REG_START_BYTE, 8'h00);
		run_phase(0, 0, 1'b1);

		$display("covered %0d bytes and %0d verdicts over six phases of register values,",
			bytes_accepted, verdicts_checked);
		$display("  with idle, stall and hold-off: ok %0d, check %0d, addr %0d, start %0d, len %0d",
			status_seen[pdx_pkg::STATUS_OK], status_seen[pdx_pkg::STATUS_BAD_CHECK],
			status_seen[pdx_pkg::STATUS_BAD_ADDR], status_seen[pdx_pkg::STATUS_BAD_START],
			status_seen[pdx_pkg::STATUS_BAD_LEN]);
		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
